### design/rcc_pkg.sv
// Shared types and constants for the RGB 3x3 convolution block.
package rcc_pkg;

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_COEF_TOP = 3'd2,
		REG_COEF_MID = 3'd3,
		REG_COEF_BOT = 3'd4
	} reg_idx_t;

	localparam int CFG_W    = 48;      // widest register
	localparam int TAP_W    = 16;      // Q4.12 tap
	localparam int PROD_W   = 25;      // 9b signed pixel x 16b tap
	localparam int ROW_W    = 27;      // sum of three products
	localparam int SUM_W    = 29;      // sum of nine products
	localparam int FRAC_W   = 12;
	localparam int PIX_MAX  = 255;
	localparam logic [CFG_W-1:0] MID_RESET = 48'd4096;   // 1.0 on the left tap of the centre row

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	// {blue, green, red}, red in the low byte
	typedef logic [23:0] pix_t;

	// Window: [r][k] holds the pixel r rows and k columns back from the newest
	typedef pix_t [2:0][2:0] win_t;

	// Tap rows indexed like the window: 0 lower, 1 centre, 2 upper
	typedef logic [2:0][CFG_W-1:0] coef_set_t;

	// Which neighbours of the centre pixel lie inside the image
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} nbr_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} res_t;

endpackage

### design/rgb_conv3x3_clamp.sv
// Top level: streaming 3x3 RGB convolution with line memory and result queue.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | kind, red, green, blue
//  out     | out_valid / out_stall| out_red, out_green, out_blue, frame_end
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// One item a cycle sustained while in_stall stays low. The result for a pixel is offered on
// out_valid once the transaction that is width+1 items behind it has passed the stage 1
// register, window register, product register, row-sum register and the queue write.
// Reset is asynchronous and takes effect at once; the line memory needs no clearing.
// in_stall rises when eight results are owed to the output (queue depth).
module rgb_conv3x3_clamp import rcc_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// pixel input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_red,
	output logic [7:0]           out_green,
	output logic [7:0]           out_blue,
	output logic                 frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(MAX_WIDTH + 2);

	// Configuration (widths held as value minus one, already saturated)
	logic [AW-1:0]   wm1_q, wm1_new;
	logic [HW-1:0]   hm1_q, hm1_new;
	coef_set_t       coef_q;
	logic [31:0]     cw, chh;
	logic            restart;

	// Input-side position counters
	logic            acc, lag_full, last_now;
	logic [LW-1:0]   lag_q;
	logic [AW-1:0]   a_q, a_next;
	logic [AW-1:0]   col_q;
	logic [HW-1:0]   row_q;
	nbr_t            nbr_now;

	// Stage 1: line memory read returns
	logic            v_s1, emit_s1, fwd_s1;
	pix_t            pix_s1;
	logic [AW-1:0]   addr_s1;
	nbr_t            nbr_s1;
	logic [47:0]     rd_s1, fwd_data_s1, line_rd, line_wd;
	logic [47:0]     line_mem [MAX_WIDTH];

	// Stage 2: window
	win_t            win_q;
	logic            v_s2;
	nbr_t            nbr_s2;

	// Output side
	logic            res_valid, deq;
	res_t            res, head;
	logic [FIFO_AW:0] cred_q;

	// Saturate width and height on write
	assign cw  = 32'(cfg_data[11:0]);
	assign chh = 32'(cfg_data[12:0]);
	assign wm1_new = (cw == 32'd0) ? '0 :
		(cw > 32'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : AW'(cw - 32'd1);
	assign hm1_new = (chh == 32'd0) ? '0 :
		(chh > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT - 1) : HW'(chh - 32'd1);
	assign restart = cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q     <= '0;
			hm1_q     <= '0;
			coef_q[0] <= '0;
			coef_q[1] <= MID_RESET;
			coef_q[2] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:    wm1_q     <= wm1_new;
				REG_HEIGHT:   hm1_q     <= hm1_new;
				REG_COEF_TOP: coef_q[2] <= cfg_data;
				REG_COEF_MID: coef_q[1] <= cfg_data;
				REG_COEF_BOT: coef_q[0] <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Accept and position bookkeeping
	assign acc      = in_valid && !in_stall;
	assign lag_full = (lag_q == LW'(wm1_q) + LW'(2));
	assign a_next   = (a_q == wm1_q) ? '0 : a_q + 1'b1;
	assign last_now = (row_q == hm1_q) && (col_q == wm1_q);
	assign nbr_now  = '{top_ok: (row_q != '0), bot_ok: (row_q != hm1_q),
		left_ok: (col_q != '0), right_ok: (col_q != wm1_q), last: last_now};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q <= '0;
			a_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			lag_q <= '0;
			a_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			priority if (!lag_full) begin
				lag_q <= lag_q + 1'b1;
				a_q   <= a_next;
			end else if (last_now) begin
				lag_q <= '0;
				a_q   <= '0;
				col_q <= '0;
				row_q <= '0;
			end else begin
				a_q <= a_next;
				if (col_q == wm1_q) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Stage 1 control; forward when the previous write hits the address being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			v_s1    <= acc;
			emit_s1 <= acc && lag_full;
			fwd_s1  <= acc && v_s1 && (addr_s1 == a_q);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= kind ? '0 : {blue, green, red};
			addr_s1 <= a_q;
			nbr_s1  <= nbr_now;
		end
		fwd_data_s1 <= line_wd;
	end

	// Line memory: entry holds {pixel two rows back, pixel one row back}
	always_ff @(posedge clk) begin
		if (v_s1)
			line_mem[addr_s1] <= line_wd;
		rd_s1 <= line_mem[a_q];
	end

	assign line_rd = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign line_wd = {line_rd[23:0], pix_s1};

	// Window shift, one column per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][2] <= win_q[r][1];
					win_q[r][1] <= win_q[r][0];
				end
				win_q[0][0] <= pix_s1;
				win_q[1][0] <= line_rd[23:0];
				win_q[2][0] <= line_rd[47:24];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			nbr_s2 <= nbr_s1;
	end

	rcc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (v_s2),
		.win       (win_q),
		.nbr       (nbr_s2),
		.coefs     (coef_q),
		.res_valid (res_valid),
		.res       (res)
	);

	rcc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (deq),
		.not_empty (out_valid),
		.head      (head)
	);

	assign deq       = out_valid && !out_stall;
	assign out_red   = head.red;
	assign out_green = head.green;
	assign out_blue  = head.blue;
	assign frame_end = head.last;

	// Results owed to the output, in flight or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			unique case ({acc && lag_full, deq})
				2'b10:   cred_q <= cred_q + 1'b1;
				2'b01:   cred_q <= cred_q - 1'b1;
				default: cred_q <= cred_q;
			endcase
		end
	end

	assign in_stall = (cred_q == (FIFO_AW+1)'(FIFO_DEPTH));

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("owed result count beyond queue depth");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		a_q <= wm1_q)
		else $error("line memory address beyond image width");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wm1_q) && (row_q <= hm1_q))
		else $error("output position outside image");

	a_emit_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && lag_full) |=> (v_s1 && emit_s1))
		else $error("releasing transaction lost before window stage");

endmodule

### design/rcc_mac.sv
// Multiply-accumulate and clamp datapath for the 3x3 window.
module rcc_mac import rcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  win_t      win,
	input  nbr_t      nbr,
	input  coef_set_t coefs,
	output logic      res_valid,
	output res_t      res
);

	logic signed [PROD_W-1:0] prod_d  [3][3][3];
	logic signed [PROD_W-1:0] prod_s3 [3][3][3];
	logic signed [ROW_W-1:0]  rsum_s4 [3][3];
	logic signed [SUM_W-1:0]  tot     [3];
	logic [7:0]               chan    [3];
	logic                     v_s3, v_s4;
	logic                     last_s3, last_s4;
	logic [2:0]               row_ok, col_ok;

	// Out-of-image neighbours count as zero
	assign row_ok = {nbr.top_ok, 1'b1, nbr.bot_ok};
	assign col_ok = {nbr.left_ok, 1'b1, nbr.right_ok};

	// Nine taps x three channels, each lane on its own
	always_comb begin
		logic [7:0]              px;
		logic signed [TAP_W-1:0] tp;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				for (int ch = 0; ch < 3; ch++) begin
					px = (row_ok[r] && col_ok[k]) ? win[r][k][8*ch +: 8] : 8'd0;
					tp = $signed(coefs[r][TAP_W*(2-k) +: TAP_W]);
					prod_d[r][k][ch] = $signed({1'b0, px}) * tp;
				end
			end
		end
	end

	// Stage 3: products
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				for (int ch = 0; ch < 3; ch++)
					prod_s3[r][k][ch] <= prod_d[r][k][ch];
		last_s3 <= nbr.last;
	end

	// Stage 4: per-row sums
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++)
			for (int ch = 0; ch < 3; ch++)
				rsum_s4[r][ch] <= ROW_W'(prod_s3[r][0][ch]) + ROW_W'(prod_s3[r][1][ch])
					+ ROW_W'(prod_s3[r][2][ch]);
		last_s4 <= last_s3;
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= en;
			v_s4 <= v_s3;
		end
	end

	// Final sum, clamp to 0..255, drop fraction
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = SUM_W'(rsum_s4[0][ch]) + SUM_W'(rsum_s4[1][ch]) + SUM_W'(rsum_s4[2][ch]);
			if (tot[ch] < 0)
				chan[ch] = 8'd0;
			else if (tot[ch][SUM_W-1:FRAC_W] > (SUM_W-FRAC_W)'(PIX_MAX))
				chan[ch] = 8'(PIX_MAX);
			else
				chan[ch] = tot[ch][FRAC_W +: 8];
		end
	end

	assign res_valid = v_s4;
	assign res       = '{red: chan[0], green: chan[1], blue: chan[2], last: last_s4};

endmodule

### design/rcc_fifo.sv
// Small result queue between the datapath and the output channel.
module rcc_fifo import rcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic not_empty,
	output res_t head
);

	res_t                 ent_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_AW:0]     cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = ent_q[rp_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("result queue written while full");

	a_ptr_level: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) == cnt_q[FIFO_AW-1:0])
		else $error("queue pointers disagree with fill level");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (FIFO_AW+1)'(FIFO_DEPTH)) |-> (wp_q == rp_q))
		else $error("full queue with pointers apart");

endmodule

### tb/tb_rgb_conv3x3_clamp.sv
// Self-checking testbench for the streaming RGB 3x3 convolution block.
`timescale 1ns / 100ps

module tb_rgb_conv3x3_clamp import rcc_pkg::*; ();

	localparam int FRAME_W_MAX    = 2048;
	localparam int FRAME_H_MAX    = 4096;
	localparam int RING_LEN       = 2 * FRAME_W_MAX + 3;
	localparam int RANDOM_ITEMS   = 650;
	localparam int STEADY_ITEMS   = 250;
	localparam int TALL_ITEMS     = 150;
	localparam int WIDE_ITEMS     = 100;
	localparam int HOLD_CYCLES    = 160;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PERCENT   = 26;

	// register indexes that decode to nothing
	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           out_red;
	logic [7:0]           out_green;
	logic [7:0]           out_blue;
	logic                 frame_end;

	// shared test control
	bit steady;        // no idling on either side while set
	bit hold_req;      // asks the output side for one long hold-off
	int fault_count;
	int items_sent;
	int quiet_cycles;

	// predictor state
	logic [11:0]      cur_width;
	logic [12:0]      cur_height;
	logic [CFG_W-1:0] tap_rows [3];     // 0 upper, 1 centre, 2 lower
	pix_t             line_ring [RING_LEN];
	logic [10:0]      out_col;
	logic [11:0]      out_row;
	logic [11:0]      fill_count;
	logic [12:0]      ring_wr;
	res_t             owed_pixels [$];

	rgb_conv3x3_clamp #(
		.MAX_WIDTH  (FRAME_W_MAX),
		.MAX_HEIGHT (FRAME_H_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_end (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// zero and over-range sizes fold into the legal span
	function automatic int eff_span(int reg_val, int top);
		if (reg_val == 0) return 1;
		if (reg_val > top) return top;
		return reg_val;
	endfunction

	function automatic int tap_value(logic [CFG_W-1:0] row_bits, int pos);
		logic signed [TAP_W-1:0] t;
		t = row_bits[TAP_W*pos +: TAP_W];
		return int'(t);
	endfunction

	// negative sums go black, then drop the fraction and saturate
	function automatic logic [7:0] clip_level(int acc);
		int q;
		if (acc < 0) return '0;
		q = acc >>> FRAC_W;
		if (q > PIX_MAX) return 8'(PIX_MAX);
		return q[7:0];
	endfunction

	function automatic int frame_len(int w, int h);
		return w * h + w + 1;
	endfunction

	function automatic void begin_new_frame();
		out_col    = '0;
		out_row    = '0;
		fill_count = '0;
		ring_wr    = '0;
	endfunction

	// one accepted input transaction: store it, and once the lag is filled
	// filter the pixel width+1 positions back
	task automatic convolve_item(input logic k, input logic [7:0] r, g, b);
		int   w, h, sz, yy, xx, idx;
		int   acc [3];
		pix_t v;
		res_t want;
		w  = eff_span(int'(cur_width), FRAME_W_MAX);
		h  = eff_span(int'(cur_height), FRAME_H_MAX);
		sz = 2 * w + 3;
		if (int'(ring_wr) >= sz)
			ring_wr = '0;
		line_ring[ring_wr] = k ? '0 : {b, g, r};
		if (int'(fill_count) < w + 1) begin
			fill_count++;
			ring_wr = (int'(ring_wr) + 1 == sz) ? '0 : ring_wr + 1'b1;
		end else begin
			for (int ch = 0; ch < 3; ch++)
				acc[ch] = 0;
			for (int dy = -1; dy <= 1; dy++) begin
				yy = int'(out_row) + dy;
				if (yy >= 0 && yy < h) begin
					for (int dx = -1; dx <= 1; dx++) begin
						xx = int'(out_col) + dx;
						if (xx >= 0 && xx < w) begin
							idx = int'(ring_wr) - (w + 1 - dy * w - dx);
							if (idx < 0)
								idx += sz;
							v = line_ring[idx];
							for (int ch = 0; ch < 3; ch++)
								acc[ch] += int'(v[8*ch +: 8]) * tap_value(tap_rows[dy+1], dx + 1);
						end
					end
				end
			end
			want.red   = clip_level(acc[0]);
			want.green = clip_level(acc[1]);
			want.blue  = clip_level(acc[2]);
			want.last  = (int'(out_row) == h - 1) && (int'(out_col) == w - 1);
			owed_pixels.push_back(want);
			if (want.last) begin
				begin_new_frame();
			end else begin
				ring_wr = (int'(ring_wr) + 1 == sz) ? '0 : ring_wr + 1'b1;
				if (int'(out_col) + 1 >= w) begin
					out_col = '0;
					out_row++;
				end else begin
					out_col++;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// register write, mirrored into the predictor
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WIDTH: begin
				cur_width = val[11:0];
				begin_new_frame();
			end
			REG_HEIGHT: begin
				cur_height = val[12:0];
				begin_new_frame();
			end
			REG_COEF_TOP: tap_rows[0] = val;
			REG_COEF_MID: tap_rows[1] = val;
			REG_COEF_BOT: tap_rows[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
		write_reg(REG_WIDTH, w_val);
		write_reg(REG_HEIGHT, h_val);
	endtask

	task automatic set_taps(input logic [CFG_W-1:0] top, mid, bot);
		write_reg(REG_COEF_TOP, top);
		write_reg(REG_COEF_MID, mid);
		write_reg(REG_COEF_BOT, bot);
	endtask

	// wild rows saturate most sums, tame rows keep them mid-range
	function automatic logic [CFG_W-1:0] pick_tap_row(bit wild);
		logic [CFG_W-1:0] row_bits;
		for (int i = 0; i < 3; i++)
			row_bits[TAP_W*i +: TAP_W] = wild ? 16'($urandom) : 16'($urandom_range(0, 3072) - 1024);
		return row_bits;
	endfunction

	// offers one transaction, with random gaps, and returns once it is taken
	task automatic send_item(input logic k, input logic [7:0] r, g, b);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		red      <= r;
		green    <= g;
		blue     <= b;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		convolve_item(k, r, g, b);
	endtask

	// items first..first+count-1 of a frame, numbered with its flush tail;
	// noisy swaps some kinds, extremes keeps every channel at 0 or 255
	task automatic send_frame_items(input int w, h, input bit noisy, extremes,
			input int first, count);
		bit         in_img;
		logic       k;
		logic [7:0] ch [3];
		for (int i = first; i < first + count; i++) begin
			in_img = (i < w * h);
			k = in_img ? 1'b0 : 1'b1;
			if (noisy && $urandom_range(0, 99) < 8)
				k = ~k;
			for (int c = 0; c < 3; c++)
				ch[c] = extremes ? {8{1'($urandom)}} : 8'($urandom);
			send_item(k, ch[0], ch[1], ch[2]);
		end
	endtask

	task automatic send_frame(input int w, h, input bit noisy, extremes);
		send_frame_items(w, h, noisy, extremes, 0, frame_len(w, h));
	endtask

	// release the input and wait until every owed result has left
	task automatic settle(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_pixels.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// output side: random stalls, or one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_pixels.size() == 0) begin
				$display("%0t ns: unexpected transaction, expected none, actual %0d/%0d/%0d end %0d",
					$time, out_red, out_green, out_blue, frame_end);
				fault_count++;
			end else begin
				want = owed_pixels.pop_front();
				check_field("out_red", want.red, out_red);
				check_field("out_green", want.green, out_green);
				check_field("out_blue", want.blue, out_blue);
				check_field("frame_end", want.last, frame_end);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset values: 1x1 frame, unit left tap of the centre row; also kinds swapped
	task automatic test_reset_identity();
		send_item(1'b0, 8'hFF, 8'h00, 8'h5A);
		send_item(1'b1, 8'h12, 8'h34, 8'h56);
		send_item(1'b1, 8'hAB, 8'hCD, 8'hEF);
		// flush inside the image reads as black, pixels in the flush tail are dropped
		send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
		send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
		send_item(1'b0, 8'h00, 8'h00, 8'h00);
		settle(DRAIN_CYCLES);
	endtask

	// extreme taps on extreme pixels, then a soft blur
	task automatic test_tap_extremes();
		set_frame(48'd3, 48'd3);
		set_taps({16'h0001, 16'h8000, 16'h7FFF}, {16'h8000, 16'h1000, 16'hFFFF},
			{16'h7FFF, 16'h0000, 16'h8000});
		send_frame(3, 3, 1'b0, 1'b1);
		settle(DRAIN_CYCLES);
		set_taps({3{16'h0200}}, {16'h0200, 16'h0400, 16'h0200}, {3{16'h0200}});
		send_frame(3, 3, 1'b0, 1'b0);
		settle(DRAIN_CYCLES);
	endtask

	// odd width with stray kinds
	task automatic test_odd_width();
		set_frame(48'd5, 48'd3);
		set_taps(pick_tap_row(1'b0), pick_tap_row(1'b0), pick_tap_row(1'b0));
		send_frame(5, 3, 1'b1, 1'b0);
		settle(DRAIN_CYCLES);
	endtask

	// ignored indexes, folded sizes and the start of the largest frames
	task automatic test_size_limits();
		write_reg(REG_SPARE_FIRST, CFG_W'({$urandom, $urandom}));
		write_reg(REG_SPARE_LAST, CFG_W'({$urandom, $urandom}));
		set_taps(pick_tap_row(1'b0), pick_tap_row(1'b0), pick_tap_row(1'b0));
		// zero width acts as one, height beyond range saturates: no early frame end
		set_frame(48'd0, 48'h1FFF);
		send_frame_items(1, FRAME_H_MAX, 1'b0, 1'b0, 0, TALL_ITEMS);
		settle(DRAIN_CYCLES);
		// zero height acts as one
		set_frame(48'd3, 48'd0);
		send_frame(3, 1, 1'b0, 1'b0);
		settle(DRAIN_CYCLES);
		// width beyond range saturates: nothing leaves inside the lag
		set_frame(48'hFFF, 48'd2);
		send_frame_items(FRAME_W_MAX, 2, 1'b0, 1'b0, 0, WIDE_ITEMS);
		settle(DRAIN_CYCLES);
	endtask

	// size writes drop a frame in flight, tap writes apply at once
	task automatic test_restart_mid_frame();
		set_frame(48'd4, 48'd3);
		set_taps(pick_tap_row(1'b0), pick_tap_row(1'b0), pick_tap_row(1'b0));
		send_frame_items(4, 3, 1'b0, 1'b0, 0, 7);
		settle(DRAIN_CYCLES);
		write_reg(REG_WIDTH, 48'd4);
		send_frame(4, 3, 1'b0, 1'b0);
		send_frame_items(4, 3, 1'b0, 1'b0, 0, 8);
		settle(DRAIN_CYCLES);
		set_taps(pick_tap_row(1'b0), pick_tap_row(1'b0), pick_tap_row(1'b0));
		send_frame_items(4, 3, 1'b0, 1'b0, 8, frame_len(4, 3) - 8);
		send_frame_items(4, 3, 1'b0, 1'b0, 0, 3);
		settle(DRAIN_CYCLES);
		write_reg(REG_HEIGHT, 48'd3);
		send_frame(4, 3, 1'b0, 1'b0);
		settle(DRAIN_CYCLES);
	endtask

	// new frame starts straight after frame_end
	task automatic test_back_to_back();
		set_frame(48'd2, 48'd2);
		repeat (3) send_frame(2, 2, 1'b0, 1'b0);
		settle(DRAIN_CYCLES);
	endtask

	// long output hold-off so the result queue fills and the input stalls
	task automatic test_backpressure();
		set_frame(48'd6, 48'd6);
		set_taps(pick_tap_row(1'b0), pick_tap_row(1'b0), pick_tap_row(1'b0));
		hold_req = 1'b1;
		send_frame(6, 6, 1'b0, 1'b0);
		settle(DRAIN_CYCLES);
	endtask

	// random sizes and taps; mostly whole frames, some noisy or cut short
	task automatic test_random_frames();
		int               start, w, h, len;
		bit               noisy;
		logic [CFG_W-1:0] junk;
		start  = items_sent;
		steady = 1'b1;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start > STEADY_ITEMS)
				steady = 1'b0;
			case ($urandom_range(0, 19))
				0:       w = $urandom_range(13, 48);
				1, 2:    w = $urandom_range(7, 12);
				default: w = $urandom_range(1, 6);
			endcase
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
			// upper data bits are junk, and a size of one is sometimes written as zero
			junk = CFG_W'({$urandom, $urandom});
			if (w == 1 && $urandom_range(0, 3) == 0)
				write_reg(REG_WIDTH, {junk[CFG_W-1:12], 12'd0});
			else
				write_reg(REG_WIDTH, {junk[CFG_W-1:12], w[11:0]});
			junk = CFG_W'({$urandom, $urandom});
			if (h == 1 && $urandom_range(0, 3) == 0)
				write_reg(REG_HEIGHT, {junk[CFG_W-1:13], 13'd0});
			else
				write_reg(REG_HEIGHT, {junk[CFG_W-1:13], h[12:0]});
			if ($urandom_range(0, 3) != 0)
				set_taps(pick_tap_row($urandom_range(0, 3) == 0),
					pick_tap_row($urandom_range(0, 3) == 0),
					pick_tap_row($urandom_range(0, 3) == 0));
			noisy = ($urandom_range(0, 9) < 3);
			len   = frame_len(w, h);
			if ($urandom_range(0, 9) == 0)
				send_frame_items(w, h, noisy, 1'b0, 0, $urandom_range(1, len - 1));
			else
				repeat ($urandom_range(1, 2)) send_frame(w, h, noisy, 1'b0);
			settle(DRAIN_CYCLES);
		end
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		kind        = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		steady      = 1'b0;
		hold_req    = 1'b0;
		fault_count = 0;
		items_sent  = 0;
		cur_width   = 12'd1;
		cur_height  = 13'd1;
		tap_rows[0] = '0;
		tap_rows[1] = MID_RESET;
		tap_rows[2] = '0;
		begin_new_frame();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_identity();
		test_tap_extremes();
		test_odd_width();
		test_restart_mid_frame();
		test_back_to_back();
		test_backpressure();
		test_size_limits();
		test_random_frames();

		settle(2 * DRAIN_CYCLES);
		if (fault_count == 0 && owed_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
